// ----- rtl/point_mass_2d_dynamics_step_unit_assert.svh -----
// Assertion macros for the point-mass step unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef POINT_MASS_2D_DYNAMICS_STEP_UNIT_ASSERT_SVH
`define POINT_MASS_2D_DYNAMICS_STEP_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define PMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define PMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// pms_pkg
// Types, constants and helper functions for the point-mass step unit.
// ----------------------------------------------------------------------------
package pms_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DT_BITS    = 16;
    localparam int ALPHA_W    = FRAC_BITS + 1;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = 32;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 3;

    localparam logic [ALPHA_W-1:0] ONE_Q = ALPHA_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ONE_P = PROD_W'(1) << FRAC_BITS;
    localparam logic [30:0] SAT31 = 31'h7FFFFFFF;
    localparam logic signed [PROD_W-1:0] MAX_P = 68'sh7FFFFFFF;
    localparam logic signed [PROD_W-1:0] MIN_P = -68'sh80000000;
    localparam logic [RAD_W-1:0] ROOT_TOP = RAD_W'(1) << (RAD_W - 2);

    typedef enum logic [IDX_W-1:0] {
        REG_RISE_RATE  = 3'd0,
        REG_FALL_RATE  = 3'd1,
        REG_ACCEL_LIM  = 3'd2,
        REG_LIN_GAIN   = 3'd3,
        REG_QUAD_GAIN  = 3'd4,
        REG_SPEED_THR  = 3'd5,
        REG_THR_RECIP  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] cmd_ax;
        logic signed [31:0] cmd_ay;
        logic [15:0]        time_step;
        logic signed [31:0] wind_accel_x;
        logic signed [31:0] wind_accel_y;
        logic signed [31:0] wind_vel_x;
        logic signed [31:0] wind_vel_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] filt_ax_out;
        logic signed [31:0] filt_ay_out;
        logic [30:0]        rel_speed;
        logic signed [31:0] drag_ax;
        logic signed [31:0] drag_ay;
        logic               skipped;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        rise_rate;
        logic [31:0]        fall_rate;
        logic [30:0]        accel_limit;
        logic [30:0]        lin_drag_gain;
        logic signed [31:0] quad_drag_gain;
        logic [30:0]        speed_threshold;
        logic [31:0]        threshold_recip;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ROOT,
        ST_DONE
    } state_t;

    // Each micro-step names the product it issues; the product of the
    // previous step is written back in the same cycle.
    typedef enum logic [4:0] {
        MS_RATE_X,
        MS_RATE_Y,
        MS_LAG_X,
        MS_LAG_Y,
        MS_SQ_X,
        MS_SQ_Y,
        MS_SQ_SUM,
        MS_LIN_X,
        MS_LIN_Y,
        MS_KGAIN,
        MS_WEIGHT,
        MS_QUAD_X,
        MS_QUAD_Y,
        MS_BLEND_X,
        MS_BLEND_Y,
        MS_VEL_X,
        MS_VEL_Y,
        MS_POS_X,
        MS_POS_Y,
        MS_POS_DONE
    } step_t;

    typedef struct packed {
        logic  load;
        logic  step_en;
        step_t step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic sqrt_busy;
    } dp_status_t;

    function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [31:0] r;
        if (v > MAX_P)
        begin
            r = 32'h7FFFFFFF;
        end
        else if (v < MIN_P)
        begin
            r = 32'h80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [PROD_W-1:0] sext32(input logic [31:0] v);
        return {{(PROD_W-32){v[31]}}, v};
    endfunction

    // Clamp a floored product to at most one; values below zero are not clamped.
    function automatic logic [ALPHA_W-1:0] clamp_unit(input logic signed [PROD_W-1:0] v);
        logic [ALPHA_W-1:0] r;
        if (v > ONE_P)
        begin
            r = ONE_Q;
        end
        else
        begin
            r = v[ALPHA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/pms_chan_if.sv -----
// ----------------------------------------------------------------------------
// pms_chan_if
// Valid/ready channels of the point-mass step unit: items, results, config.
// ----------------------------------------------------------------------------
interface pms_item_if;
    logic               valid;
    logic               ready;
    pms_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pms_result_if;
    logic               valid;
    logic               ready;
    pms_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pms_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pms_pkg::IDX_W-1:0]   index;
    logic [31:0]                 wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/point_mass_2d_dynamics_step_unit.sv -----
// Each accepted beat walks 7 micro-steps, waits on the bit-serial square root
// unit, walks 13 more micro-steps and is then output.
// A beat with a zero time step gives its result in the next cycle.
// One beat is in flight at a time, set by the single shared multiplier and
// the one-bit-per-cycle root unit; the next beat is taken once the result goes.
// Reset (rst_n, asynchronous): state and filters zero, registers at defaults.
// ----------------------------------------------------------------------------
// point_mass_2d_dynamics_step_unit
// 2D point-mass step: command lag, saturation, wind drag and Euler update.
// ----------------------------------------------------------------------------
`include "point_mass_2d_dynamics_step_unit_assert.svh"

module point_mass_2d_dynamics_step_unit
(
    input  logic         clk,
    input  logic         rst_n,
    pms_item_if.sink     item,
    pms_result_if.source result,
    pms_cfg_if.sink      cfg
);

    pms_pkg::cfg_regs_t  cfg_regs_reg;
    pms_pkg::ctrl_cmd_t  cmd;
    pms_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.rise_rate       <= 32'd1310720;
            cfg_regs_reg.fall_rate       <= 32'd1310720;
            cfg_regs_reg.accel_limit     <= 31'd655360;
            cfg_regs_reg.lin_drag_gain   <= '0;
            cfg_regs_reg.quad_drag_gain  <= '0;
            cfg_regs_reg.speed_threshold <= '0;
            cfg_regs_reg.threshold_recip <= '0;
        end
        else if (cfg.valid)
        begin
            case (pms_pkg::cfg_index_t'(cfg.index))
                pms_pkg::REG_RISE_RATE: cfg_regs_reg.rise_rate       <= cfg.wdata;
                pms_pkg::REG_FALL_RATE: cfg_regs_reg.fall_rate       <= cfg.wdata;
                pms_pkg::REG_ACCEL_LIM: cfg_regs_reg.accel_limit     <= cfg.wdata[30:0];
                pms_pkg::REG_LIN_GAIN:  cfg_regs_reg.lin_drag_gain   <= cfg.wdata[30:0];
                pms_pkg::REG_QUAD_GAIN: cfg_regs_reg.quad_drag_gain  <= cfg.wdata;
                pms_pkg::REG_SPEED_THR: cfg_regs_reg.speed_threshold <= cfg.wdata[30:0];
                pms_pkg::REG_THR_RECIP: cfg_regs_reg.threshold_recip <= cfg.wdata;
                default:                cfg_regs_reg                 <= cfg_regs_reg;
            endcase
        end
    end

    pms_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    pms_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_regs    (cfg_regs_reg),
        .item_data   (item.data),
        .result_data (result.data)
    );

    `PMS_ASSERT_SAME(a_one_in_flight, result.valid, !item.ready, "input taken while a result waits")
    `PMS_ASSERT_SAME(a_skip_clean, result.valid && result.data.skipped, (result.data.drag_ax == 32'sd0) && (result.data.drag_ay == 32'sd0) && (result.data.rel_speed == '0), "skipped beat shows drag or speed")
    `PMS_ASSERT_NEXT(a_skip_fast, item.valid && item.ready && (item.data.time_step == '0), result.valid && result.data.skipped, "zero time step not reported next cycle")

endmodule

// ----- rtl/pms_isqrt.sv -----
// ----------------------------------------------------------------------------
// pms_isqrt
// Integer square root, one result bit per cycle, restoring method.
// ----------------------------------------------------------------------------
module pms_isqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pms_pkg::RAD_W-1:0]   radicand,
    output logic                        busy,
    output logic [pms_pkg::ROOT_W-1:0]  root
);

    logic [pms_pkg::RAD_W-1:0] n_reg;
    logic [pms_pkg::RAD_W-1:0] r_reg;
    logic [pms_pkg::RAD_W-1:0] bit_reg;
    logic [pms_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic [pms_pkg::RAD_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            r_reg    <= '0;
            bit_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            n_reg    <= radicand;
            r_reg    <= '0;
            bit_reg  <= pms_pkg::ROOT_TOP;
            cnt_reg  <= pms_pkg::CNT_W'(pms_pkg::ROOT_STEPS - 1);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[pms_pkg::ROOT_W-1:0];

endmodule

// ----- rtl/pms_datapath.sv -----
// ----------------------------------------------------------------------------
// pms_datapath
// State, working registers and one shared 34x34 multiplier. Each micro-step
// issues one product and writes back the product of the step before.
// ----------------------------------------------------------------------------
module pms_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pms_pkg::ctrl_cmd_t      cmd,
    output pms_pkg::dp_status_t     status,
    input  pms_pkg::cfg_regs_t      cfg_regs,
    input  pms_pkg::in_item_t       item_data,
    output pms_pkg::out_item_t      result_data
);

    localparam int PW = pms_pkg::PROD_W;
    localparam int MW = pms_pkg::MUL_W;
    localparam int AW = pms_pkg::ALPHA_W;

    logic signed [31:0] cmd_x_reg, cmd_y_reg, wax_reg, way_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] rx_reg, ry_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic signed [31:0] filt_x_reg, filt_y_reg;
    logic [AW-1:0]      alpha_x_reg, alpha_y_reg, w_reg;
    logic [63:0]        sq_reg;
    logic [30:0]        norm_reg;
    logic signed [31:0] lin_x_reg, lin_y_reg, k_reg, quad_x_reg, quad_y_reg;
    logic signed [31:0] drag_x_reg, drag_y_reg;
    logic               skip_reg;
    logic signed [PW-1:0] prod_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] sh, neg_sh;
    logic [31:0]          rate_x, rate_y;
    logic signed [32:0]   diff_x, diff_y, qd_x, qd_y;
    logic [32:0]          mag_x, mag_y;
    logic signed [31:0]   nd;
    logic signed [MW-1:0] ax, ay;
    logic                 big, use_quad, sqrt_start, sqrt_busy;
    logic [31:0]          root;
    logic [30:0]          norm_val;

    function automatic logic [31:0] clamp_lim(input logic signed [PW-1:0] f,
                                              input logic [30:0] lim);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        logic [31:0]          r;
        hi = {{(PW-31){1'b0}}, lim};
        lo = -hi;
        if (f > hi)
        begin
            r = hi[31:0];
        end
        else if (f < lo)
        begin
            r = lo[31:0];
        end
        else
        begin
            r = f[31:0];
        end
        return r;
    endfunction

    assign rate_x = (cmd_x_reg > filt_x_reg) ? cfg_regs.rise_rate : cfg_regs.fall_rate;
    assign rate_y = (cmd_y_reg > filt_y_reg) ? cfg_regs.rise_rate : cfg_regs.fall_rate;
    assign diff_x = {cmd_x_reg[31], cmd_x_reg} - {filt_x_reg[31], filt_x_reg};
    assign diff_y = {cmd_y_reg[31], cmd_y_reg} - {filt_y_reg[31], filt_y_reg};
    assign mag_x  = rx_reg[32] ? 33'(-rx_reg) : 33'(rx_reg);
    assign mag_y  = ry_reg[32] ? 33'(-ry_reg) : 33'(ry_reg);
    assign nd     = {1'b0, norm_reg} - {1'b0, cfg_regs.speed_threshold};
    assign qd_x   = {quad_x_reg[31], quad_x_reg} - {lin_x_reg[31], lin_x_reg};
    assign qd_y   = {quad_y_reg[31], quad_y_reg} - {lin_y_reg[31], lin_y_reg};
    assign ax     = {{2{filt_x_reg[31]}}, filt_x_reg} + {{2{drag_x_reg[31]}}, drag_x_reg}
                  + {{2{wax_reg[31]}}, wax_reg};
    assign ay     = {{2{filt_y_reg[31]}}, filt_y_reg} + {{2{drag_y_reg[31]}}, drag_y_reg}
                  + {{2{way_reg[31]}}, way_reg};

    // A component at or above the 31-bit maximum saturates the norm outright.
    assign big      = (mag_x >= {2'b00, pms_pkg::SAT31}) || (mag_y >= {2'b00, pms_pkg::SAT31});
    assign norm_val = big ? pms_pkg::SAT31
                    : ((root > {1'b0, pms_pkg::SAT31}) ? pms_pkg::SAT31 : root[30:0]);
    assign use_quad = (cfg_regs.quad_drag_gain > 32'sd0) && (cfg_regs.speed_threshold != '0)
                    && (norm_reg > cfg_regs.speed_threshold);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            pms_pkg::MS_RATE_X:
            begin
                mul_a = {2'b00, rate_x};
                mul_b = {18'b0, dt_reg};
            end
            pms_pkg::MS_RATE_Y:
            begin
                mul_a = {2'b00, rate_y};
                mul_b = {18'b0, dt_reg};
            end
            pms_pkg::MS_LAG_X:
            begin
                mul_a = {{(MW-AW){1'b0}}, alpha_x_reg};
                mul_b = {diff_x[32], diff_x};
            end
            pms_pkg::MS_LAG_Y:
            begin
                mul_a = {{(MW-AW){1'b0}}, alpha_y_reg};
                mul_b = {diff_y[32], diff_y};
            end
            pms_pkg::MS_SQ_X:
            begin
                mul_a = {1'b0, mag_x};
                mul_b = {1'b0, mag_x};
            end
            pms_pkg::MS_SQ_Y:
            begin
                mul_a = {1'b0, mag_y};
                mul_b = {1'b0, mag_y};
            end
            pms_pkg::MS_LIN_X:
            begin
                mul_a = {3'b000, cfg_regs.lin_drag_gain};
                mul_b = {rx_reg[32], rx_reg};
            end
            pms_pkg::MS_LIN_Y:
            begin
                mul_a = {3'b000, cfg_regs.lin_drag_gain};
                mul_b = {ry_reg[32], ry_reg};
            end
            pms_pkg::MS_KGAIN:
            begin
                mul_a = {{2{cfg_regs.quad_drag_gain[31]}}, cfg_regs.quad_drag_gain};
                mul_b = {3'b000, norm_reg};
            end
            pms_pkg::MS_WEIGHT:
            begin
                mul_a = {{2{nd[31]}}, nd};
                mul_b = {2'b00, cfg_regs.threshold_recip};
            end
            pms_pkg::MS_QUAD_X:
            begin
                mul_a = {{2{k_reg[31]}}, k_reg};
                mul_b = {rx_reg[32], rx_reg};
            end
            pms_pkg::MS_QUAD_Y:
            begin
                mul_a = {{2{k_reg[31]}}, k_reg};
                mul_b = {ry_reg[32], ry_reg};
            end
            pms_pkg::MS_BLEND_X:
            begin
                mul_a = {{(MW-AW){1'b0}}, w_reg};
                mul_b = {qd_x[32], qd_x};
            end
            pms_pkg::MS_BLEND_Y:
            begin
                mul_a = {{(MW-AW){1'b0}}, w_reg};
                mul_b = {qd_y[32], qd_y};
            end
            pms_pkg::MS_VEL_X:
            begin
                mul_a = ax;
                mul_b = {18'b0, dt_reg};
            end
            pms_pkg::MS_VEL_Y:
            begin
                mul_a = ay;
                mul_b = {18'b0, dt_reg};
            end
            pms_pkg::MS_POS_X:
            begin
                mul_a = {{2{vel_x_reg[31]}}, vel_x_reg};
                mul_b = {18'b0, dt_reg};
            end
            pms_pkg::MS_POS_Y:
            begin
                mul_a = {{2{vel_y_reg[31]}}, vel_y_reg};
                mul_b = {18'b0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign sh         = prod_reg >>> pms_pkg::FRAC_BITS;
    assign neg_sh     = -sh;
    assign sqrt_start = cmd.step_en && (cmd.step == pms_pkg::MS_SQ_SUM);

    pms_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg + prod_reg[63:0]),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_x_reg   <= '0;
            cmd_y_reg   <= '0;
            wax_reg     <= '0;
            way_reg     <= '0;
            dt_reg      <= '0;
            rx_reg      <= '0;
            ry_reg      <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            filt_x_reg  <= '0;
            filt_y_reg  <= '0;
            alpha_x_reg <= '0;
            alpha_y_reg <= '0;
            w_reg       <= '0;
            sq_reg      <= '0;
            norm_reg    <= '0;
            lin_x_reg   <= '0;
            lin_y_reg   <= '0;
            k_reg       <= '0;
            quad_x_reg  <= '0;
            quad_y_reg  <= '0;
            drag_x_reg  <= '0;
            drag_y_reg  <= '0;
            skip_reg    <= 1'b0;
            prod_reg    <= '0;
        end
        else if (cmd.load)
        begin
            cmd_x_reg  <= item_data.cmd_ax;
            cmd_y_reg  <= item_data.cmd_ay;
            wax_reg    <= item_data.wind_accel_x;
            way_reg    <= item_data.wind_accel_y;
            dt_reg     <= item_data.time_step;
            rx_reg     <= {vel_x_reg[31], vel_x_reg} - {item_data.wind_vel_x[31], item_data.wind_vel_x};
            ry_reg     <= {vel_y_reg[31], vel_y_reg} - {item_data.wind_vel_y[31], item_data.wind_vel_y};
            norm_reg   <= '0;
            drag_x_reg <= '0;
            drag_y_reg <= '0;
            skip_reg   <= (item_data.time_step == '0);
        end
        else if (cmd.step_en)
        begin
            prod_reg <= prod_next;
            case (cmd.step)
                pms_pkg::MS_RATE_Y:   alpha_x_reg <= pms_pkg::clamp_unit(sh);
                pms_pkg::MS_LAG_X:    alpha_y_reg <= pms_pkg::clamp_unit(sh);
                pms_pkg::MS_LAG_Y:    filt_x_reg  <= clamp_lim(pms_pkg::sext32(filt_x_reg) + sh,
                                                               cfg_regs.accel_limit);
                pms_pkg::MS_SQ_X:     filt_y_reg  <= clamp_lim(pms_pkg::sext32(filt_y_reg) + sh,
                                                               cfg_regs.accel_limit);
                pms_pkg::MS_SQ_Y:     sq_reg      <= prod_reg[63:0];
                pms_pkg::MS_LIN_X:    norm_reg    <= norm_val;
                pms_pkg::MS_LIN_Y:    lin_x_reg   <= pms_pkg::sat32(neg_sh);
                pms_pkg::MS_KGAIN:    lin_y_reg   <= pms_pkg::sat32(neg_sh);
                pms_pkg::MS_WEIGHT:   k_reg       <= pms_pkg::sat32(sh);
                pms_pkg::MS_QUAD_X:   w_reg       <= pms_pkg::clamp_unit(sh);
                pms_pkg::MS_QUAD_Y:   quad_x_reg  <= pms_pkg::sat32(neg_sh);
                pms_pkg::MS_BLEND_X:  quad_y_reg  <= pms_pkg::sat32(neg_sh);
                pms_pkg::MS_BLEND_Y:  drag_x_reg  <= use_quad
                                                   ? pms_pkg::sat32(pms_pkg::sext32(lin_x_reg) + sh)
                                                   : lin_x_reg;
                pms_pkg::MS_VEL_X:    drag_y_reg  <= use_quad
                                                   ? pms_pkg::sat32(pms_pkg::sext32(lin_y_reg) + sh)
                                                   : lin_y_reg;
                pms_pkg::MS_VEL_Y:    vel_x_reg   <= pms_pkg::sat32(pms_pkg::sext32(vel_x_reg) + sh);
                pms_pkg::MS_POS_X:    vel_y_reg   <= pms_pkg::sat32(pms_pkg::sext32(vel_y_reg) + sh);
                pms_pkg::MS_POS_Y:    pos_x_reg   <= pms_pkg::sat32(pms_pkg::sext32(pos_x_reg) + sh);
                pms_pkg::MS_POS_DONE: pos_y_reg   <= pms_pkg::sat32(pms_pkg::sext32(pos_y_reg) + sh);
                default:              sq_reg      <= sq_reg;
            endcase
        end
    end

    assign status.dt_zero   = (item_data.time_step == '0);
    assign status.sqrt_busy = sqrt_busy;

    assign result_data.pos_x_out   = pos_x_reg;
    assign result_data.pos_y_out   = pos_y_reg;
    assign result_data.vel_x_out   = vel_x_reg;
    assign result_data.vel_y_out   = vel_y_reg;
    assign result_data.filt_ax_out = filt_x_reg;
    assign result_data.filt_ay_out = filt_y_reg;
    assign result_data.rel_speed   = norm_reg;
    assign result_data.drag_ax     = drag_x_reg;
    assign result_data.drag_ay     = drag_y_reg;
    assign result_data.skipped     = skip_reg;

endmodule

// ----- rtl/pms_ctrl.sv -----
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: accepts a beat, walks the micro-steps, waits on the root unit
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pms_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  pms_pkg::dp_status_t  status,
    output pms_pkg::ctrl_cmd_t   cmd
);

    pms_pkg::state_t state_reg, state_next;
    pms_pkg::step_t  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pms_pkg::ST_IDLE;
            step_reg  <= pms_pkg::MS_RATE_X;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        cmd.load     = 1'b0;
        cmd.step_en  = 1'b0;
        cmd.step     = step_reg;
        case (state_reg)
            pms_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    // A zero time step changes nothing and reports at once.
                    if (status.dt_zero)
                    begin
                        state_next = pms_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = pms_pkg::ST_RUN;
                        step_next  = pms_pkg::MS_RATE_X;
                    end
                end
            end
            pms_pkg::ST_RUN:
            begin
                cmd.step_en = 1'b1;
                if (step_reg == pms_pkg::MS_SQ_SUM)
                begin
                    state_next = pms_pkg::ST_ROOT;
                    step_next  = pms_pkg::MS_LIN_X;
                end
                else if (step_reg == pms_pkg::MS_POS_DONE)
                begin
                    state_next = pms_pkg::ST_DONE;
                end
                else
                begin
                    step_next = pms_pkg::step_t'(step_reg + 5'd1);
                end
            end
            pms_pkg::ST_ROOT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = pms_pkg::ST_RUN;
                end
            end
            pms_pkg::ST_DONE:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    state_next = pms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/sv/point_mass_2d_dynamics_step_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_mass_2d_dynamics_step_unit_test
// Drives step commands with random pacing, writes the drag and lag registers
// between phases and checks every result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module point_mass_2d_dynamics_step_unit_test;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    pms_item_if   item();
    pms_result_if result();
    pms_cfg_if    cfg();

    point_mass_2d_dynamics_step_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Predictor state and registers.
    pms_pkg::cfg_regs_t regs;
    longint    p_pos_x, p_pos_y, p_vel_x, p_vel_y, p_filt_x, p_filt_y;

    pms_pkg::out_item_t expected_steps[$];
    int        error_count;
    int        idle_cycles;
    bit        hold_off;
    bit        stall_enable;

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7FFFFFFF)
        begin
            return 64'sh7FFFFFFF;
        end
        if (v < -64'sh80000000)
        begin
            return -64'sh80000000;
        end
        return v;
    endfunction

    function automatic longint int_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint lag_filter(input longint cmd, input longint filt,
                                          input longint dt);
        longint unsigned rate;
        longint unsigned prod;
        longint alpha;
        longint f;
        longint lim;
        rate = (cmd > filt) ? longint'(regs.rise_rate) : longint'(regs.fall_rate);
        prod = (rate * longint'(dt)) >> 16;
        alpha = (prod > 65536) ? 65536 : longint'(prod);
        lim = longint'(regs.accel_limit);
        f = filt + floor_shift(alpha * (cmd - filt), 16);
        if (f > lim)
        begin
            f = lim;
        end
        if (f < -lim)
        begin
            f = -lim;
        end
        return f;
    endfunction

    function automatic longint drag_term(input longint v, input longint speed);
        longint lin;
        longint k;
        longint quad;
        longint w;
        longint qg;
        longint thr;
        longint unsigned wu;
        qg = longint'(regs.quad_drag_gain);
        thr = longint'(regs.speed_threshold);
        lin = clamp32(-floor_shift(longint'(regs.lin_drag_gain) * v, 16));
        if (qg <= 0 || thr == 0 || speed <= thr)
        begin
            return lin;
        end
        k = clamp32(floor_shift(qg * speed, 16));
        quad = clamp32(-floor_shift(k * v, 16));
        wu = (longint'(speed - thr) * longint'(regs.threshold_recip)) >> 16;
        w = (wu > 65536) ? 65536 : longint'(wu);
        return clamp32(lin + floor_shift(w * (quad - lin), 16));
    endfunction

    function automatic pms_pkg::out_item_t predict_step(input pms_pkg::in_item_t in);
        pms_pkg::out_item_t o;
        longint dt;
        longint rx, ry, mx, my, speed, dx, dy, ax, ay;
        dt = longint'(in.time_step);
        speed = 0;
        dx = 0;
        dy = 0;
        if (dt != 0)
        begin
            p_filt_x = lag_filter(longint'(in.cmd_ax), p_filt_x, dt);
            p_filt_y = lag_filter(longint'(in.cmd_ay), p_filt_y, dt);
            rx = p_vel_x - longint'(in.wind_vel_x);
            ry = p_vel_y - longint'(in.wind_vel_y);
            mx = (rx < 0) ? -rx : rx;
            my = (ry < 0) ? -ry : ry;
            if (mx >= 64'h7FFFFFFF || my >= 64'h7FFFFFFF)
            begin
                speed = 64'h7FFFFFFF;
            end
            else
            begin
                speed = int_root(longint'(mx * mx + my * my));
                if (speed > 64'h7FFFFFFF)
                begin
                    speed = 64'h7FFFFFFF;
                end
            end
            dx = drag_term(rx, speed);
            dy = drag_term(ry, speed);
            ax = p_filt_x + dx + longint'(in.wind_accel_x);
            ay = p_filt_y + dy + longint'(in.wind_accel_y);
            p_vel_x = clamp32(p_vel_x + floor_shift(ax * dt, 16));
            p_vel_y = clamp32(p_vel_y + floor_shift(ay * dt, 16));
            p_pos_x = clamp32(p_pos_x + floor_shift(p_vel_x * dt, 16));
            p_pos_y = clamp32(p_pos_y + floor_shift(p_vel_y * dt, 16));
        end
        o.pos_x_out   = p_pos_x[31:0];
        o.pos_y_out   = p_pos_y[31:0];
        o.vel_x_out   = p_vel_x[31:0];
        o.vel_y_out   = p_vel_y[31:0];
        o.filt_ax_out = p_filt_x[31:0];
        o.filt_ay_out = p_filt_y[31:0];
        o.rel_speed   = speed[30:0];
        o.drag_ax     = dx[31:0];
        o.drag_ay     = dy[31:0];
        o.skipped     = (dt == 0);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Valid stays high after the beat goes, so that the next beat can follow
    // at once; whoever pauses the sender drops it.
    task automatic send_step(input pms_pkg::in_item_t in);
        item.valid <= 1'b1;
        item.data  <= in;
        @(posedge clk);
        while (!item.ready)
        begin
            @(posedge clk);
        end
        expected_steps.push_back(predict_step(in));
    endtask

    task automatic write_reg(input pms_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= value;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            pms_pkg::REG_RISE_RATE: regs.rise_rate = value;
            pms_pkg::REG_FALL_RATE: regs.fall_rate = value;
            pms_pkg::REG_ACCEL_LIM: regs.accel_limit = value[30:0];
            pms_pkg::REG_LIN_GAIN:  regs.lin_drag_gain = value[30:0];
            pms_pkg::REG_QUAD_GAIN: regs.quad_drag_gain = value;
            pms_pkg::REG_SPEED_THR: regs.speed_threshold = value[30:0];
            pms_pkg::REG_THR_RECIP: regs.threshold_recip = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_steps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] rr, input logic [31:0] fr,
                             input logic [31:0] lim, input logic [31:0] lg,
                             input logic [31:0] qg, input logic [31:0] thr,
                             input logic [31:0] rc);
        wait_drained();
        write_reg(pms_pkg::REG_RISE_RATE, rr);
        write_reg(pms_pkg::REG_FALL_RATE, fr);
        write_reg(pms_pkg::REG_ACCEL_LIM, lim);
        write_reg(pms_pkg::REG_LIN_GAIN, lg);
        write_reg(pms_pkg::REG_QUAD_GAIN, qg);
        write_reg(pms_pkg::REG_SPEED_THR, thr);
        write_reg(pms_pkg::REG_THR_RECIP, rc);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            3: return 32'($signed($urandom_range(0, 80000)) - 40000);
            default: return $urandom();
        endcase
    endfunction

    function automatic pms_pkg::in_item_t rand_step(input bit mild);
        pms_pkg::in_item_t in;
        in.cmd_ax = mild ? 32'($signed($urandom_range(0, 1600000)) - 800000) : rand_word();
        in.cmd_ay = mild ? 32'($signed($urandom_range(0, 1600000)) - 800000) : rand_word();
        case ($urandom_range(0, 9))
            0: in.time_step = 16'd0;
            1: in.time_step = 16'hFFFF;
            2: in.time_step = 16'($urandom());
            default: in.time_step = 16'($urandom_range(1, 3000));
        endcase
        in.wind_accel_x = mild ? 32'($signed($urandom_range(0, 200000)) - 100000)
                               : rand_word();
        in.wind_accel_y = mild ? 32'($signed($urandom_range(0, 200000)) - 100000)
                               : rand_word();
        in.wind_vel_x = mild ? 32'($signed($urandom_range(0, 4000000)) - 2000000)
                             : rand_word();
        in.wind_vel_y = mild ? 32'($signed($urandom_range(0, 4000000)) - 2000000)
                             : rand_word();
        return in;
    endfunction

    // Bursts of beats; after most bursts, and after the last, valid drops for a random gap.
    task automatic send_random(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < count)
            begin
                send_step(rand_step($urandom_range(0, 3) != 0));
                sent++;
                burst--;
            end
            if (sent >= count || $urandom_range(0, 2) != 0)
            begin
                item.valid <= 1'b0;
                repeat ($urandom_range(1, 70)) @(posedge clk);
            end
        end
    endtask

    task automatic test_directed();
        pms_pkg::in_item_t in;
        in = '0;
        send_step(in);
        in.time_step = 16'd1;
        in.cmd_ax = 32'sh7FFFFFFF;
        in.cmd_ay = 32'sh80000000;
        send_step(in);
        in.time_step = 16'hFFFF;
        send_step(in);
        in.cmd_ax = 32'sh80000000;
        in.cmd_ay = 32'sh7FFFFFFF;
        in.wind_vel_x = 32'sh7FFFFFFF;
        in.wind_vel_y = 32'sh80000000;
        send_step(in);
        in.time_step = 16'd0;
        send_step(in);
        in.wind_accel_x = 32'sh7FFFFFFF;
        in.wind_accel_y = 32'sh7FFFFFFF;
        in.time_step = 16'hFFFF;
        repeat (4) send_step(in);
        in.wind_accel_x = 32'sh80000000;
        in.wind_accel_y = 32'sh80000000;
        repeat (8) send_step(in);
        in = '0;
        in.time_step = 16'd6553;
        in.wind_vel_x = 32'sh00140000;
        in.wind_vel_y = -32'sh000A0000;
        repeat (3) send_step(in);
        item.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_default_regs();
        send_random(300);
    endtask

    task automatic test_linear_drag();
        write_all(32'h00100000, 32'h00050000, 32'h00200000, 32'h00008000,
                  32'h00004000, 32'h0, 32'h0);
        send_random(300);
    endtask

    task automatic test_quadratic_blend();
        write_all(32'h00040000, 32'h00080000, 32'h000A0000, 32'h00010000,
                  32'h00002000, 32'h00050000, 32'h00003333);
        send_random(300);
    endtask

    task automatic test_extreme_regs();
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        send_random(200);
        write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0);
        send_random(150);
        write_all(32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF,
                  32'h00010000, 32'h00010000);
        send_random(150);
    endtask

    // The receiver holds off for a fixed stretch while beats keep coming,
    // then the sender waits for every result before carrying on.
    task automatic test_backpressure();
        write_all($urandom(), $urandom(), {1'b0, 31'($urandom())}, 32'($urandom_range(0, 90000)),
                  32'($urandom_range(0, 20000)), 32'($urandom_range(1, 400000)),
                  $urandom());
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(5);
        join
        wait_drained();
        send_random(500);
    endtask

    always @(posedge clk)
    begin
        if (hold_off)
        begin
            result.ready <= 1'b0;
        end
        else if (stall_enable)
        begin
            result.ready <= ($urandom_range(0, 3) != 0);
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    // The ready pattern switches between stalling and free-running stretches.
    initial
    begin
        stall_enable = 1'b0;
        forever
        begin
            repeat ($urandom_range(50, 800)) @(posedge clk);
            stall_enable = ~stall_enable;
        end
    end

    always @(posedge clk)
    begin
        pms_pkg::out_item_t got;
        pms_pkg::out_item_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got = result.data;
            if (expected_steps.size() == 0)
            begin
                report_mismatch("unexpected result beat", 0, 0);
            end
            else
            begin
                want = expected_steps.pop_front();
                if (got.pos_x_out !== want.pos_x_out)
                    report_mismatch("pos_x_out", got.pos_x_out, want.pos_x_out);
                if (got.pos_y_out !== want.pos_y_out)
                    report_mismatch("pos_y_out", got.pos_y_out, want.pos_y_out);
                if (got.vel_x_out !== want.vel_x_out)
                    report_mismatch("vel_x_out", got.vel_x_out, want.vel_x_out);
                if (got.vel_y_out !== want.vel_y_out)
                    report_mismatch("vel_y_out", got.vel_y_out, want.vel_y_out);
                if (got.filt_ax_out !== want.filt_ax_out)
                    report_mismatch("filt_ax_out", got.filt_ax_out, want.filt_ax_out);
                if (got.filt_ay_out !== want.filt_ay_out)
                    report_mismatch("filt_ay_out", got.filt_ay_out, want.filt_ay_out);
                if (got.rel_speed !== want.rel_speed)
                    report_mismatch("rel_speed", got.rel_speed, want.rel_speed);
                if (got.drag_ax !== want.drag_ax)
                    report_mismatch("drag_ax", got.drag_ax, want.drag_ax);
                if (got.drag_ay !== want.drag_ay)
                    report_mismatch("drag_ay", got.drag_ay, want.drag_ay);
                if (got.skipped !== want.skipped)
                    report_mismatch("skipped", got.skipped, want.skipped);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready) || hold_off)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.data = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.wdata = '0;
        result.ready = 1'b0;
        hold_off = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        regs.rise_rate = 32'd1310720;
        regs.fall_rate = 32'd1310720;
        regs.accel_limit = 31'd655360;
        regs.lin_drag_gain = '0;
        regs.quad_drag_gain = '0;
        regs.speed_threshold = '0;
        regs.threshold_recip = '0;
        p_pos_x = 0;
        p_pos_y = 0;
        p_vel_x = 0;
        p_vel_y = 0;
        p_filt_x = 0;
        p_filt_y = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_default_regs();
        test_linear_drag();
        test_quadratic_blend();
        test_extreme_regs();
        test_backpressure();
        wait_drained();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pms_pkg.sv
rtl/pms_chan_if.sv
rtl/pms_isqrt.sv
rtl/pms_datapath.sv
rtl/pms_ctrl.sv
rtl/point_mass_2d_dynamics_step_unit.sv
tb/sv/point_mass_2d_dynamics_step_unit_test.sv
